// ===== hdl/pwm_period_duty_meter_core_macros.svh =====
// assertion macros for the pwm period and duty meter
`ifndef PWM_PERIOD_DUTY_METER_CORE_MACROS_SVH
`define PWM_PERIOD_DUTY_METER_CORE_MACROS_SVH

// same-cycle implication, checked on the clock, off during reset
`define PDM_ASSERT_NOW(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (consq)) \
      else $error(msg);

// next-cycle implication, checked on the clock, off during reset
`define PDM_ASSERT_NEXT(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consq)) \
      else $error(msg);

`endif

// ===== hdl/pdm_pkg.sv =====
// shared types and constants of the pwm period and duty meter
package pdm_pkg;

   localparam int RATE_W  = 27;
   localparam int DUTY_W  = 7;
   localparam int TICKS_W = 16;

   localparam logic [RATE_W-1:0] RATE_RESET = 27'd8000000;
   localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_DONE = 3'b100
   } back_state_type;

endpackage

// ===== hdl/pdm_front.sv =====
// edge detection and tick counting, emits one period record per completed period
module pdm_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_level,
   input  logic                  q_full,
   output logic                  rec_push,
   output logic [COUNT_BITS-1:0] rec_high,
   output logic [COUNT_BITS-1:0] rec_low,
   output logic                  rec_sat
);
   import pdm_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   logic                  prev_ff, prev_in;
   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] high_ff, high_in;
   logic                  sat_ff, sat_in;
   logic                  fire, rising, falling;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  count_at_max;

   assign req_stall    = q_full;
   assign fire         = req_valid & ~req_stall;
   assign rising       = req_level & ~prev_ff;
   assign falling      = ~req_level & prev_ff;
   assign count_at_max = (count_ff == COUNT_MAX);
   assign count_inc    = count_at_max ? count_ff : count_ff + COUNT_ONE;

   assign rec_push = fire & (phase_ff == PH_LOW) & rising;
   assign rec_high = high_ff;
   assign rec_low  = count_ff;
   assign rec_sat  = sat_ff;

   always_comb begin
      prev_in  = prev_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      high_in  = high_ff;
      sat_in   = sat_ff;
      if (fire) begin
         prev_in = req_level;
         case (phase_ff)
            PH_HIGH: begin
               if (falling) begin
                  high_in  = count_ff;
                  count_in = COUNT_ONE;
                  phase_in = PH_LOW;
               end else begin
                  count_in = count_inc;
                  sat_in   = sat_ff | count_at_max;
               end
            end
            PH_LOW: begin
               if (rising) begin
                  count_in = COUNT_ONE;
                  sat_in   = 1'b0;
                  phase_in = PH_HIGH;
               end else begin
                  count_in = count_inc;
                  sat_in   = sat_ff | count_at_max;
               end
            end
            default: begin
               if (rising) begin
                  count_in = COUNT_ONE;
                  sat_in   = 1'b0;
                  phase_in = PH_HIGH;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         high_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ===== hdl/pdm_queue.sv =====
// two-entry queue of period records between front and back
module pdm_queue #(
   parameter int DATA_W = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   output logic              valid,
   output logic [DATA_W-1:0] rdata,
   input  logic              pop
);
   import pdm_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hdl/pdm_back.sv =====
// shift-subtract dividers for frequency and duty, and the result register
module pdm_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pdm_pkg::RATE_W-1:0]    tick_rate,
   input  logic                          rec_valid,
   input  logic [COUNT_BITS-1:0]         rec_high,
   input  logic [COUNT_BITS-1:0]         rec_low,
   input  logic                          rec_sat,
   output logic                          rec_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pdm_pkg::RATE_W-1:0]    rsp_freq_hz,
   output logic [pdm_pkg::DUTY_W-1:0]    rsp_duty_percent,
   output logic [pdm_pkg::TICKS_W-1:0]   rsp_high_ticks,
   output logic [pdm_pkg::TICKS_W-1:0]   rsp_low_ticks,
   output logic                          rsp_overrun
);
   import pdm_pkg::*;

   localparam int DEN_W  = COUNT_BITS + 1;
   localparam int PROD_W = COUNT_BITS + DUTY_W;
   localparam int NUM_W  = (PROD_W > RATE_W) ? PROD_W : RATE_W;
   localparam int ITER_W = $clog2(NUM_W + 1);

   back_state_type     state_ff, state_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   fnum_ff, fnum_in;
   logic [DEN_W-1:0]   frem_ff, frem_in;
   logic [NUM_W-1:0]   dnum_ff, dnum_in;
   logic [DEN_W-1:0]   drem_ff, drem_in;
   logic [TICKS_W-1:0] hi_ff, hi_in;
   logic [TICKS_W-1:0] lo_ff, lo_in;
   logic               sat_ff, sat_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  freq_ff;
   logic [DUTY_W-1:0]  duty_ff;
   logic [TICKS_W-1:0] rhi_ff;
   logic [TICKS_W-1:0] rlo_ff;
   logic               rsat_ff;

   logic [PROD_W-1:0]  prod;
   logic [DEN_W:0]     f_trial, d_trial;
   logic               f_ge, d_ge;
   logic               out_load;

   assign prod    = PROD_W'(rec_high) * PROD_W'(DUTY_SCALE);
   assign f_trial = {frem_ff, fnum_ff[NUM_W-1]};
   assign d_trial = {drem_ff, dnum_ff[NUM_W-1]};
   assign f_ge    = (f_trial >= {1'b0, den_ff});
   assign d_ge    = (d_trial >= {1'b0, den_ff});

   assign rec_pop  = (state_ff == BK_IDLE) & rec_valid;
   assign out_load = (state_ff == BK_DONE) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      den_in   = den_ff;
      fnum_in  = fnum_ff;
      frem_in  = frem_ff;
      dnum_in  = dnum_ff;
      drem_in  = drem_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      sat_in   = sat_ff;
      case (state_ff)
         BK_IDLE: begin
            if (rec_valid) begin
               den_in   = DEN_W'(rec_high) + DEN_W'(rec_low);
               fnum_in  = NUM_W'(tick_rate);
               dnum_in  = NUM_W'(prod);
               frem_in  = '0;
               drem_in  = '0;
               hi_in    = TICKS_W'(rec_high);
               lo_in    = TICKS_W'(rec_low);
               sat_in   = rec_sat;
               iter_in  = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            fnum_in = {fnum_ff[NUM_W-2:0], f_ge};
            dnum_in = {dnum_ff[NUM_W-2:0], d_ge};
            frem_in = f_ge ? DEN_W'(f_trial - {1'b0, den_ff}) : f_trial[DEN_W-1:0];
            drem_in = d_ge ? DEN_W'(d_trial - {1'b0, den_ff}) : d_trial[DEN_W-1:0];
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(NUM_W - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      den_ff  <= den_in;
      fnum_ff <= fnum_in;
      frem_ff <= frem_in;
      dnum_ff <= dnum_in;
      drem_ff <= drem_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      sat_ff  <= sat_in;
      if (out_load) begin
         freq_ff <= fnum_ff[RATE_W-1:0];
         duty_ff <= dnum_ff[DUTY_W-1:0];
         rhi_ff  <= hi_ff;
         rlo_ff  <= lo_ff;
         rsat_ff <= sat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_freq_hz      = freq_ff;
   assign rsp_duty_percent = duty_ff;
   assign rsp_high_ticks   = rhi_ff;
   assign rsp_low_ticks    = rlo_ff;
   assign rsp_overrun      = rsat_ff;

endmodule

// ===== hdl/pwm_period_duty_meter_core.sv =====
// Top level of the pwm period and duty meter. One level sample is taken per clock on the
// request channel; req_stall stays low and no sample is missed as long as fewer than two
// finished periods wait for the divider. Each finished period then passes through the back
// end (two max(27, COUNT_BITS + 7)-bit shift-subtract dividers running side by side, one
// quotient bit per cycle) before its result is offered on the response channel; the back
// end takes a new period only after the last result is loaded. Periods are at least two
// samples long, so a steady input only stalls when its periods are shorter than the time
// the back end spends on one. csr_wdata sets the tick rate and should be written while idle.
module pwm_period_duty_meter_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [pdm_pkg::RATE_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pdm_pkg::RATE_W-1:0]    rsp_freq_hz,
   output logic [pdm_pkg::DUTY_W-1:0]    rsp_duty_percent,
   output logic [pdm_pkg::TICKS_W-1:0]   rsp_high_ticks,
   output logic [pdm_pkg::TICKS_W-1:0]   rsp_low_ticks,
   output logic                          rsp_overrun
);
   import pdm_pkg::*;

   localparam int REC_W = 2 * COUNT_BITS + 1;

   logic [RATE_W-1:0]     rate_ff;
   logic [RATE_W-1:0]     rate_in;
   logic                  q_full, q_valid, rec_push, rec_pop;
   logic [COUNT_BITS-1:0] push_high, push_low;
   logic                  push_sat;
   logic [REC_W-1:0]      q_rdata;

   assign rate_in = csr_wen ? csr_wdata : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   pdm_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_level (req_level),
      .q_full    (q_full),
      .rec_push  (rec_push),
      .rec_high  (push_high),
      .rec_low   (push_low),
      .rec_sat   (push_sat)
   );

   pdm_queue #(.DATA_W(REC_W)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .wdata ({push_sat, push_high, push_low}),
      .full  (q_full),
      .valid (q_valid),
      .rdata (q_rdata),
      .pop   (rec_pop)
   );

   pdm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .tick_rate        (rate_ff),
      .rec_valid        (q_valid),
      .rec_high         (q_rdata[2*COUNT_BITS-1:COUNT_BITS]),
      .rec_low          (q_rdata[COUNT_BITS-1:0]),
      .rec_sat          (q_rdata[REC_W-1]),
      .rec_pop          (rec_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_freq_hz      (rsp_freq_hz),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_overrun      (rsp_overrun)
   );

endmodule

// ===== hdl/pdm_checker.sv =====
// port-level checks of the pwm period and duty meter, bound to the top level
`include "pwm_period_duty_meter_core_macros.svh"

module pdm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pdm_pkg::RATE_W-1:0]    rsp_freq_hz,
   input logic [pdm_pkg::DUTY_W-1:0]    rsp_duty_percent,
   input logic [pdm_pkg::TICKS_W-1:0]   rsp_high_ticks,
   input logic [pdm_pkg::TICKS_W-1:0]   rsp_low_ticks,
   input logic                          rsp_overrun
);
   import pdm_pkg::*;

   logic [RATE_W+DUTY_W+2*TICKS_W:0] rsp_payload;

   assign rsp_payload = {rsp_freq_hz, rsp_duty_percent, rsp_high_ticks, rsp_low_ticks,
                         rsp_overrun};

   `PDM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
   `PDM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload), "stalled response changed")
   `PDM_ASSERT_NOW(a_duty_range, rsp_valid, rsp_duty_percent <= DUTY_SCALE, "duty above full scale")
   `PDM_ASSERT_NOW(a_freq_range, rsp_valid, rsp_freq_hz[RATE_W-1] == 1'b0, "frequency above half the tick rate")

endmodule

bind pwm_period_duty_meter_core pdm_checker u_checker (.*);
